>>> sv/aavr_pkg.sv
// aavr_pkg: shared constants, latency figures and arithmetic helpers for the
// axis-angle vector rotation core; no dependencies

package aavr_pkg;

  localparam int DEF_FRAC_BITS    = 16;
  localparam int DEF_CORDIC_STEPS = 16;
  localparam int ATAN_N           = 30;

  // q.30 angle constants
  localparam logic [63:0] PI_Q30      = 64'd3373259426;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;

  localparam logic [31:0] ATAN_Q30 [ATAN_N] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149,
    32'd1048576,   32'd524288,    32'd262144,    32'd131072,    32'd65536,
    32'd32768,     32'd16384,     32'd8192,      32'd4096,      32'd2048,
    32'd1024,      32'd512,       32'd256,       32'd128,       32'd64,
    32'd32,        32'd16,        32'd8,         32'd4,         32'd2
  };

  // pipeline depths of the shared units
  localparam int ISQ_LAT = 32;
  localparam int DIV_LAT = 33;
  localparam int AX_LAT  = 2 + ISQ_LAT + DIV_LAT;
  localparam int MV_LAT  = 6;

  function automatic int steps_eff(input int s);
    int r;
    r = s;
    if (r > ATAN_N) r = ATAN_N;
    if (r < 1) r = 1;
    return r;
  endfunction

  function automatic int mod_steps(input int f);
    return 30 - f;
  endfunction

  function automatic int ang_lat(input int f, input int s);
    return mod_steps(f) + steps_eff(s) + 71;
  endfunction

  function automatic int total_lat(input int f, input int s);
    return ang_lat(f, s) + MV_LAT;
  endfunction

  // magnitude of a signed value, truncated to 33 bits
  function automatic logic [32:0] mag33(input logic signed [37:0] v);
    logic [37:0] m;
    m = v[37] ? 38'(-v) : 38'(v);
    return m[32:0];
  endfunction

  // round half away from zero of a magnitude product over 2^30, then sign
  function automatic logic signed [37:0] rnd_q30(input logic [65:0] p, input logic neg);
    logic [65:0] t;
    logic signed [37:0] m;
    t = (p + (66'd1 << 29)) >> 30;
    m = $signed({2'b00, t[35:0]});
    return neg ? -m : m;
  endfunction

endpackage

>>> sv/aavr_delay.sv
// aavr_delay: plain shift line that aligns side data with the datapath
// no dependencies

module aavr_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] sr_r [DEPTH];

  always_ff @(posedge clk) begin
    sr_r[0] <= din;
    for (int i = 1; i < DEPTH; i++) begin
      sr_r[i] <= sr_r[i-1];
    end
  end

  assign dout = sr_r[DEPTH-1];

endmodule

>>> sv/aavr_isqrt.sv
// aavr_isqrt: pipelined floor square root of a 64-bit value, one root bit a stage
// no dependencies

module aavr_isqrt (
  input  logic        clk,
  input  logic [63:0] rad,
  output logic [31:0] root
);

  logic [63:0] rem_r  [32];
  logic [31:0] root_r [32];

  for (genvar k = 0; k < 32; k++) begin : g_stg
    localparam int B = 31 - k;
    logic [63:0] rem_in;
    logic [63:0] trial;
    logic [31:0] root_in;

    if (k == 0) begin : g_first
      assign rem_in  = rad;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end

    // (r + 2^b)^2 - r^2
    assign trial = ({32'd0, root_in} << (B + 1)) | (64'd1 << (2 * B));

    always_ff @(posedge clk) begin
      if (rem_in >= trial) begin
        rem_r[k]  <= rem_in - trial;
        root_r[k] <= root_in | (32'd1 << B);
      end else begin
        rem_r[k]  <= rem_in;
        root_r[k] <= root_in;
      end
    end
  end

  assign root = root_r[31];

endmodule

>>> sv/aavr_div.sv
// aavr_div: pipelined restoring divider, sign * round(num * 2^30 / den)
// no dependencies; the quotient magnitude is known to fit 31 bits

module aavr_div (
  input  logic               clk,
  input  logic [31:0]        num_mag,
  input  logic               num_neg,
  input  logic [31:0]        den,
  output logic signed [31:0] quo
);

  logic [62:0] rem_r [32];
  logic [31:0] den_r [32];
  logic [30:0] q_r   [32];
  logic        neg_r [32];
  logic signed [31:0] quo_r;

  // prep: numerator with half the divisor added for rounding
  always_ff @(posedge clk) begin
    rem_r[0] <= {1'b0, num_mag, 30'd0} + {32'd0, den[31:1]};
    den_r[0] <= den;
    q_r[0]   <= '0;
    neg_r[0] <= num_neg;
  end

  for (genvar k = 1; k < 32; k++) begin : g_stg
    localparam int I = 31 - k;
    logic [62:0] cst;
    assign cst = {31'd0, den_r[k-1]} << I;

    always_ff @(posedge clk) begin
      den_r[k] <= den_r[k-1];
      neg_r[k] <= neg_r[k-1];
      if (rem_r[k-1] >= cst) begin
        rem_r[k] <= rem_r[k-1] - cst;
        q_r[k]   <= q_r[k-1] | (31'd1 << I);
      end else begin
        rem_r[k] <= rem_r[k-1];
        q_r[k]   <= q_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= neg_r[31] ? -$signed({1'b0, q_r[31]}) : $signed({1'b0, q_r[31]});
  end

  assign quo = quo_r;

endmodule

>>> sv/aavr_angle.sv
// aavr_angle: angle reduction, cordic, gain removal; gives sin, cos and 1 - cos
// depends on aavr_pkg, aavr_delay, aavr_isqrt, aavr_div

module aavr_angle import aavr_pkg::*; #(
  parameter int FRAC_BITS    = DEF_FRAC_BITS,
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
  input  logic               clk,
  input  logic signed [31:0] ang_in,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o,
  output logic signed [32:0] omc_o
);

  localparam int MOD   = mod_steps(FRAC_BITS);
  localparam int STEPS = steps_eff(CORDIC_STEPS);
  localparam int MAG_W = 62 - FRAC_BITS;

  localparam logic signed [34:0] PI_S   = $signed(PI_Q30[34:0]);
  localparam logic signed [34:0] HPI_S  = $signed(HALF_PI_Q30[34:0]);
  localparam logic signed [34:0] TPI_S  = $signed(TWO_PI_Q30[34:0]);
  localparam logic signed [32:0] ONE_S  = $signed(ONE_Q30[32:0]);

  // scale to q.30 magnitude
  logic [31:0]      am;
  logic [MAG_W-1:0] amag_r;
  logic             aneg_r;

  assign am = ang_in[31] ? 32'(-ang_in) : 32'(ang_in);

  always_ff @(posedge clk) begin
    amag_r <= MAG_W'(am) << (30 - FRAC_BITS);
    aneg_r <= ang_in[31];
  end

  // remainder by 2*pi, one shifted subtract a stage
  logic [MAG_W-1:0] md_r   [MOD];
  logic             mdn_r  [MOD];

  for (genvar k = 0; k < MOD; k++) begin : g_mod
    localparam logic [MAG_W-1:0] CST = MAG_W'(TWO_PI_Q30 << (MOD - 1 - k));
    logic [MAG_W-1:0] rin;
    logic             nin;
    if (k == 0) begin : g_first
      assign rin = amag_r;
      assign nin = aneg_r;
    end else begin : g_next
      assign rin = md_r[k-1];
      assign nin = mdn_r[k-1];
    end
    always_ff @(posedge clk) begin
      md_r[k]  <= (rin >= CST) ? rin - CST : rin;
      mdn_r[k] <= nin;
    end
  end

  // wrap to [-pi, pi]
  logic signed [34:0] rs;
  logic signed [34:0] wr_r;

  assign rs = mdn_r[MOD-1] ? -$signed({2'b00, md_r[MOD-1][32:0]})
                           :  $signed({2'b00, md_r[MOD-1][32:0]});

  always_ff @(posedge clk) begin
    if (rs > PI_S) begin
      wr_r <= rs - TPI_S;
    end else if (rs < -PI_S) begin
      wr_r <= rs + TPI_S;
    end else begin
      wr_r <= rs;
    end
  end

  // fold into [-pi/2, pi/2], cosine flips
  logic signed [34:0] fz;
  logic signed [32:0] fz_r;
  logic               ff_r;

  always_comb begin
    if (wr_r > HPI_S) begin
      fz = PI_S - wr_r;
    end else if (wr_r < -HPI_S) begin
      fz = -PI_S - wr_r;
    end else begin
      fz = wr_r;
    end
  end

  always_ff @(posedge clk) begin
    fz_r <= fz[32:0];
    ff_r <= (wr_r > HPI_S) || (wr_r < -HPI_S);
  end

  // cordic rotation, one micro-rotation a stage
  logic signed [32:0] cx_r [STEPS];
  logic signed [32:0] cy_r [STEPS];
  logic signed [32:0] cz_r [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_cor
    logic signed [32:0] xin, yin, zin, at;
    if (i == 0) begin : g_first
      assign xin = ONE_S;
      assign yin = '0;
      assign zin = fz_r;
    end else begin : g_next
      assign xin = cx_r[i-1];
      assign yin = cy_r[i-1];
      assign zin = cz_r[i-1];
    end
    assign at = $signed({1'b0, ATAN_Q30[i]});
    always_ff @(posedge clk) begin
      if (!zin[32]) begin
        cx_r[i] <= xin - (yin >>> i);
        cy_r[i] <= yin + (xin >>> i);
        cz_r[i] <= zin - at;
      end else begin
        cx_r[i] <= xin + (yin >>> i);
        cy_r[i] <= yin - (xin >>> i);
        cz_r[i] <= zin + at;
      end
    end
  end

  // vector length for gain removal
  logic [32:0] xm_w, ym_w;
  logic [63:0] sqx_r, sqy_r, lsq_r;
  logic [31:0] len;
  logic [31:0] len_d;

  assign xm_w = mag33(38'(cx_r[STEPS-1]));
  assign ym_w = mag33(38'(cy_r[STEPS-1]));

  always_ff @(posedge clk) begin
    sqx_r <= xm_w[31:0] * xm_w[31:0];
    sqy_r <= ym_w[31:0] * ym_w[31:0];
    lsq_r <= sqx_r + sqy_r;
  end

  aavr_isqrt u_len (.clk(clk), .rad(lsq_r), .root(len));

  assign len_d = (len == '0) ? 32'd1 : len;

  // x, y magnitudes wait for the root
  logic [65:0] xy_d;
  aavr_delay #(.WIDTH(66), .DEPTH(2 + ISQ_LAT)) u_xy_dly (
    .clk(clk),
    .din({cx_r[STEPS-1][32], xm_w[31:0], cy_r[STEPS-1][32], ym_w[31:0]}),
    .dout(xy_d)
  );

  // fold flag rides past the cordic, root and divider stages
  logic flip_d;
  aavr_delay #(.WIDTH(1), .DEPTH(STEPS + 2 + ISQ_LAT + DIV_LAT)) u_flip_dly (
    .clk(clk), .din(ff_r), .dout(flip_d)
  );

  logic signed [31:0] cq, sq;

  aavr_div u_cos (.clk(clk), .num_mag(xy_d[64:33]), .num_neg(xy_d[65]),
                  .den(len_d), .quo(cq));
  aavr_div u_sin (.clk(clk), .num_mag(xy_d[31:0]), .num_neg(xy_d[32]),
                  .den(len_d), .quo(sq));

  logic signed [31:0] c2;
  logic signed [31:0] sin_r, cos_r;
  logic signed [32:0] omc_r;

  assign c2 = flip_d ? -cq : cq;

  always_ff @(posedge clk) begin
    sin_r <= sq;
    cos_r <= c2;
    omc_r <= ONE_S - 33'(c2);
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;
  assign omc_o = omc_r;

endmodule

>>> sv/aavr_matvec.sv
// aavr_matvec: builds the rodrigues matrix and applies it to the vector,
// saturating the result; depends on aavr_pkg

module aavr_matvec import aavr_pkg::*; (
  input  logic               clk,
  input  logic signed [31:0] k_i   [3],
  input  logic signed [31:0] sin_i,
  input  logic signed [31:0] cos_i,
  input  logic signed [32:0] omc_i,
  input  logic signed [31:0] v_i   [3],
  input  logic               zero_i,
  output logic signed [31:0] rot_o [3],
  output logic               zero_o,
  output logic               sat_o
);

  // carried side data per stage
  logic signed [31:0] c_r   [4];
  logic signed [32:0] omc_r [2];
  logic signed [31:0] v_r   [5][3];
  logic               z_r   [5];

  // p1: k_i * k_j and k_i * s
  logic [63:0] kkp_r [3][3];
  logic        kkn_r [3][3];
  logic [63:0] ksp_r [3];
  logic        ksn_r [3];

  // p2: rounded
  logic signed [37:0] kk_r [3][3];
  logic signed [37:0] ks2_r [3];

  // p3: kk * (1 - c)
  logic [65:0] kop_r [3][3];
  logic        kon_r [3][3];
  logic signed [37:0] ks3_r [3];

  // p4: matrix
  logic signed [37:0] m_r [3][3];

  // p5: m * v
  logic [65:0] mvp_r [3][3];
  logic        mvn_r [3][3];

  // p6: outputs
  logic signed [31:0] rot_r [3];
  logic               zero_r, sat_r;

  logic [32:0] smag, omag;

  assign smag = mag33(38'(sin_i));
  assign omag = mag33(38'(omc_r[1]));

  always_ff @(posedge clk) begin
    c_r[0]   <= cos_i;
    omc_r[0] <= omc_i;
    omc_r[1] <= omc_r[0];
    for (int s = 1; s < 4; s++) c_r[s] <= c_r[s-1];
    v_r[0] <= v_i;
    z_r[0] <= zero_i;
    for (int s = 1; s < 5; s++) begin
      v_r[s] <= v_r[s-1];
      z_r[s] <= z_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        kkp_r[i][j] <= 64'(mag33(38'(k_i[i])) * mag33(38'(k_i[j])));
        kkn_r[i][j] <= k_i[i][31] ^ k_i[j][31];
        kk_r[i][j]  <= rnd_q30({2'b00, kkp_r[i][j]}, kkn_r[i][j]);
        kop_r[i][j] <= 66'(mag33(kk_r[i][j]) * omag);
        kon_r[i][j] <= kk_r[i][j][37] ^ omc_r[1][32];
      end
      ksp_r[i] <= 64'(mag33(38'(k_i[i])) * smag);
      ksn_r[i] <= k_i[i][31] ^ sin_i[31];
      ks2_r[i] <= rnd_q30({2'b00, ksp_r[i]}, ksn_r[i]);
      ks3_r[i] <= ks2_r[i];
    end
  end

  // p4: (1-c) k k^T + c I + s [k]x, cross term index is the third axis
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (i == j) begin
          m_r[i][j] <= rnd_q30(kop_r[i][j], kon_r[i][j]) + 38'(c_r[2]);
        end else if (j == (i + 1) % 3) begin
          m_r[i][j] <= rnd_q30(kop_r[i][j], kon_r[i][j]) - ks3_r[3 - i - j];
        end else begin
          m_r[i][j] <= rnd_q30(kop_r[i][j], kon_r[i][j]) + ks3_r[3 - i - j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        mvp_r[i][j] <= 66'(mag33(m_r[i][j]) * mag33(38'(v_r[3][j])));
        mvn_r[i][j] <= m_r[i][j][37] ^ v_r[3][j][31];
      end
    end
  end

  // p6: row sums, clamp, zero-axis bypass
  logic signed [39:0] acc [3];
  logic               ovf [3];
  logic signed [31:0] clp [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = 40'(rnd_q30(mvp_r[i][0], mvn_r[i][0]))
             + 40'(rnd_q30(mvp_r[i][1], mvn_r[i][1]))
             + 40'(rnd_q30(mvp_r[i][2], mvn_r[i][2]));
      if (acc[i] > 40'sd2147483647) begin
        clp[i] = 32'sh7fffffff;
        ovf[i] = 1'b1;
      end else if (acc[i] < -40'sd2147483648) begin
        clp[i] = 32'sh80000000;
        ovf[i] = 1'b1;
      end else begin
        clp[i] = acc[i][31:0];
        ovf[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    zero_r <= z_r[4];
    if (z_r[4]) begin
      rot_r <= v_r[4];
      sat_r <= 1'b0;
    end else begin
      rot_r <= clp;
      sat_r <= ovf[0] | ovf[1] | ovf[2];
    end
  end

  assign rot_o  = rot_r;
  assign zero_o = zero_r;
  assign sat_o  = sat_r;

endmodule

>>> sv/axis_angle_vector_rotation_core.sv
// axis_angle_vector_rotation_core: top level of the rodrigues rotation pipeline
// depends on aavr_pkg, aavr_delay, aavr_isqrt, aavr_div, aavr_angle, aavr_matvec
//
// usage
//   input beat: start high with busy low takes vec, axis and angle (signed
//   q16.16 at the default FRAC_BITS); busy stays low, so a beat can enter on
//   every clock
//   result beat: out_valid is high for exactly one cycle with out_rot_*,
//   out_axis_zero and out_saturated; the receiver cannot stall, it must take
//   the beat in that cycle
//   latency: (30 - FRAC_BITS) + CORDIC_STEPS + 77 cycles (CORDIC_STEPS held to
//   1..30), 107 cycles at the defaults; it is set by the angle path: remainder
//   by 2*pi, cordic, a 32-stage square root and a 33-stage divider, then six
//   matrix stages
//   throughput: one beat per cycle, results leave in order
//   reset: rst_n is synchronous; it clears the valid line, so no result beat
//   comes out for beats that were in flight
//   a zero axis passes the vector unchanged and raises out_axis_zero

module axis_angle_vector_rotation_core import aavr_pkg::*; #(
  parameter int FRAC_BITS    = DEF_FRAC_BITS,
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_vec_x,
  input  logic signed [31:0] in_vec_y,
  input  logic signed [31:0] in_vec_z,
  input  logic signed [31:0] in_axis_x,
  input  logic signed [31:0] in_axis_y,
  input  logic signed [31:0] in_axis_z,
  input  logic signed [31:0] in_turn_angle,
  output logic               out_valid,
  output logic signed [31:0] out_rot_x,
  output logic signed [31:0] out_rot_y,
  output logic signed [31:0] out_rot_z,
  output logic               out_axis_zero,
  output logic               out_saturated
);

  localparam int ANG_LAT = ang_lat(FRAC_BITS, CORDIC_STEPS);
  localparam int LAT     = total_lat(FRAC_BITS, CORDIC_STEPS);
  localparam int PAD     = ANG_LAT - AX_LAT;

  // fully pipelined, never holds off a beat
  assign busy = 1'b0;

  logic accept;
  assign accept = start & ~busy;

  // valid bit travels alongside the datapath
  logic [LAT-1:0] vld_r, vld_nxt;

  always_comb begin
    vld_nxt = {vld_r[LAT-2:0], accept};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign out_valid = vld_r[LAT-1];

  // axis path: squared magnitudes, norm, then each component over the norm
  logic signed [31:0] ax [3];
  logic [31:0]        amag [3];
  logic [63:0]        sq_r [3];
  logic [31:0]        amag_r [3];
  logic               aneg_r [3];
  logic [63:0]        nsq_r;
  logic [31:0]        nroot;

  assign ax[0] = in_axis_x;
  assign ax[1] = in_axis_y;
  assign ax[2] = in_axis_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      amag[i] = ax[i][31] ? 32'(-ax[i]) : 32'(ax[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq_r[i]   <= amag[i] * amag[i];
      amag_r[i] <= amag[i];
      aneg_r[i] <= ax[i][31];
    end
    nsq_r <= sq_r[0] + sq_r[1] + sq_r[2];
  end

  aavr_isqrt u_norm (.clk(clk), .rad(nsq_r), .root(nroot));

  // unit axis, lined up with sin and cos
  logic signed [31:0] kq [3];
  logic signed [31:0] kj [3];

  for (genvar i = 0; i < 3; i++) begin : g_axis
    logic [32:0] ad;
    aavr_delay #(.WIDTH(33), .DEPTH(1 + ISQ_LAT)) u_adly (
      .clk(clk), .din({aneg_r[i], amag_r[i]}), .dout(ad)
    );
    aavr_div u_kdiv (.clk(clk), .num_mag(ad[31:0]), .num_neg(ad[32]),
                     .den(nroot), .quo(kq[i]));
    aavr_delay #(.WIDTH(32), .DEPTH(PAD)) u_kdly (
      .clk(clk), .din(kq[i]), .dout(kj[i])
    );
  end

  // angle path
  logic signed [31:0] sn, cs;
  logic signed [32:0] omc;

  aavr_angle #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_angle (
    .clk(clk), .ang_in(in_turn_angle), .sin_o(sn), .cos_o(cs), .omc_o(omc)
  );

  // vector and zero-axis flag wait for the angle path
  logic        az;
  logic [96:0] vd;
  logic signed [31:0] vj [3];

  assign az = (in_axis_x == '0) && (in_axis_y == '0) && (in_axis_z == '0);

  aavr_delay #(.WIDTH(97), .DEPTH(ANG_LAT)) u_vdly (
    .clk(clk), .din({az, in_vec_x, in_vec_y, in_vec_z}), .dout(vd)
  );

  assign vj[0] = vd[95:64];
  assign vj[1] = vd[63:32];
  assign vj[2] = vd[31:0];

  // matrix build and multiply
  logic signed [31:0] rot [3];

  aavr_matvec u_matvec (
    .clk(clk), .k_i(kj), .sin_i(sn), .cos_i(cs), .omc_i(omc), .v_i(vj),
    .zero_i(vd[96]), .rot_o(rot), .zero_o(out_axis_zero), .sat_o(out_saturated)
  );

  assign out_rot_x = rot[0];
  assign out_rot_y = rot[1];
  assign out_rot_z = rot[2];

endmodule

>>> sv/aavr_checker.sv
// aavr_checker: port-level checks of the rotation core, bound to the top level
// depends on aavr_pkg and axis_angle_vector_rotation_core

module aavr_checker #(
  parameter int LAT = 1
) (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic signed [31:0] in_vec_x,
  input logic signed [31:0] in_vec_y,
  input logic signed [31:0] in_vec_z,
  input logic               out_valid,
  input logic signed [31:0] out_rot_x,
  input logic signed [31:0] out_rot_y,
  input logic signed [31:0] out_rot_z,
  input logic               out_axis_zero,
  input logic               out_saturated
);

  // every accepted beat returns after the fixed latency
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("accepted beat did not produce a result");

  // no result beat without a matching input beat
  a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result beat without an input beat");

  // zero axis hands the vector back untouched
  a_zero_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_axis_zero) |-> (!out_saturated
      && out_rot_x == $past(in_vec_x, LAT)
      && out_rot_y == $past(in_vec_y, LAT)
      && out_rot_z == $past(in_vec_z, LAT)))
    else $error("zero axis did not pass the vector");

  // saturation shows as a component at a bound
  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_rot_x == 32'sh7fffffff || out_rot_x == 32'sh80000000
       || out_rot_y == 32'sh7fffffff || out_rot_y == 32'sh80000000
       || out_rot_z == 32'sh7fffffff || out_rot_z == 32'sh80000000))
    else $error("saturated flag without a clamped component");

endmodule

bind axis_angle_vector_rotation_core aavr_checker #(
  .LAT(aavr_pkg::total_lat(FRAC_BITS, CORDIC_STEPS))
) u_aavr_checker (.*);

>>> tb/tb.sv
// tb: self-checking bench for axis_angle_vector_rotation_core
// depends on aavr_pkg and the core; predicts each rotation in fixed point
`timescale 1ns / 100ps

module tb import aavr_pkg::*; ();

  localparam int LAT       = total_lat(DEF_FRAC_BITS, DEF_CORDIC_STEPS);
  localparam int N_RANDOM  = 1500;
  localparam int CYCLE_MAX = 200000;

  // one input beat
  typedef struct {
    logic signed [31:0] vx, vy, vz, ax, ay, az, ang;
  } rot_req_t;

  // one result beat
  typedef struct {
    logic signed [31:0] rx, ry, rz;
    logic               zero_axis;
    logic               clamped;
  } rot_res_t;

  logic clk, rst_n, start, busy, out_valid, out_axis_zero, out_saturated;
  logic signed [31:0] in_vec_x, in_vec_y, in_vec_z;
  logic signed [31:0] in_axis_x, in_axis_y, in_axis_z, in_turn_angle;
  logic signed [31:0] out_rot_x, out_rot_y, out_rot_z;

  rot_req_t pending_q[$];
  rot_res_t expected_q[$];
  rot_req_t cur_req;
  logic     busy_at_edge;
  int       n_errors;
  int       cycle_cnt;
  int       gap_left;
  bit       stim_done;
  bit       no_gaps;

  axis_angle_vector_rotation_core u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_vec_x(in_vec_x), .in_vec_y(in_vec_y), .in_vec_z(in_vec_z),
    .in_axis_x(in_axis_x), .in_axis_y(in_axis_y), .in_axis_z(in_axis_z),
    .in_turn_angle(in_turn_angle),
    .out_valid(out_valid), .out_rot_x(out_rot_x), .out_rot_y(out_rot_y),
    .out_rot_z(out_rot_z), .out_axis_zero(out_axis_zero),
    .out_saturated(out_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------
  // fixed point arithmetic of the rotation, 64-bit signed
  // ---------------------------------------------------------------

  function automatic longint unsigned absval(input longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  // rounded half away from zero product over 2^30
  function automatic longint qmul(input longint a, input longint b);
    longint unsigned p;
    p = absval(a) * absval(b);
    p = (p + (64'd1 << 29)) >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // sign(num) * round_half_up(|num| * 2^30 / den)
  function automatic longint qdiv(input longint num, input longint unsigned den);
    longint unsigned q;
    q = ((absval(num) << 30) + (den >> 1)) / den;
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clamp_to32(input longint v, inout logic hit);
    if (v > 64'sd2147483647) begin
      hit = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      hit = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // sine and cosine of a q.30 angle through range reduction, cordic and gain removal
  task automatic cordic_sincos(input longint ang, output longint sn, output longint cs);
    longint r, x, y, z, dx, dy;
    longint pi_v, hpi_v, tpi_v;
    longint unsigned len;
    bit flip;
    int steps;
    pi_v = longint'(PI_Q30);
    hpi_v = longint'(HALF_PI_Q30);
    tpi_v = longint'(TWO_PI_Q30);
    steps = steps_eff(DEF_CORDIC_STEPS);
    r = ang % tpi_v;
    flip = 0;
    if (r > pi_v) r -= tpi_v;
    if (r < -pi_v) r += tpi_v;
    if (r > hpi_v) begin
      r = pi_v - r;
      flip = 1;
    end else if (r < -hpi_v) begin
      r = -pi_v - r;
      flip = 1;
    end
    x = longint'(ONE_Q30);
    y = 0;
    z = r;
    for (int i = 0; i < steps; i++) begin
      // >>> on signed longint floors, as the arithmetic shift wants
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_Q30[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_Q30[i]);
      end
    end
    len = floor_sqrt(absval(x) * absval(x) + absval(y) * absval(y));
    if (len == 0) len = 1;
    sn = qdiv(y, len);
    cs = qdiv(x, len);
    if (flip) cs = -cs;
  endtask

  // expected result beat of one rotation request
  task automatic predict_rotation(input rot_req_t rq, output rot_res_t rs);
    longint v[3], a[3], k[3], m[3][3], acc, sn, cs, omc, ang;
    longint unsigned nsq, nrm;
    logic hit;
    v[0] = rq.vx; v[1] = rq.vy; v[2] = rq.vz;
    a[0] = rq.ax; a[1] = rq.ay; a[2] = rq.az;
    nsq = 0;
    hit = 1'b0;
    for (int i = 0; i < 3; i++) nsq += absval(a[i]) * absval(a[i]);
    if (nsq == 0) begin
      // zero axis: the vector passes unchanged
      rs.rx = rq.vx; rs.ry = rq.vy; rs.rz = rq.vz;
      rs.zero_axis = 1'b1;
      rs.clamped = 1'b0;
      return;
    end
    nrm = floor_sqrt(nsq);
    for (int i = 0; i < 3; i++) k[i] = qdiv(a[i], nrm);
    ang = longint'(rq.ang) * (64'sd1 <<< (30 - DEF_FRAC_BITS));
    cordic_sincos(ang, sn, cs);
    omc = longint'(ONE_Q30) - cs;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        m[i][j] = qmul(qmul(k[i], k[j]), omc);
    for (int i = 0; i < 3; i++) m[i][i] += cs;
    m[0][1] -= qmul(k[2], sn);
    m[0][2] += qmul(k[1], sn);
    m[1][0] += qmul(k[2], sn);
    m[1][2] -= qmul(k[0], sn);
    m[2][0] -= qmul(k[1], sn);
    m[2][1] += qmul(k[0], sn);
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += qmul(m[i][j], v[j]);
      acc = clamp_to32(acc, hit);
      if (i == 0) rs.rx = acc[31:0];
      else if (i == 1) rs.ry = acc[31:0];
      else rs.rz = acc[31:0];
    end
    rs.zero_axis = 1'b0;
    rs.clamped = hit;
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    n_errors++;
    $display("error at cycle %0d: %s got %0d expected %0d", cycle_cnt, what, got, want);
  endtask

  // ---------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------

  function automatic logic [31:0] rand_word();
    // mix of full-range, small and edge values so every bit toggles
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'(int'($urandom_range(0, 131072)) - 65536);
      3, 4: return 32'(int'($urandom_range(0, 8388608)) - 4194304);
      default: return $urandom();
    endcase
  endfunction

  task automatic add_req(input logic [31:0] vx, vy, vz, ax, ay, az, ang);
    rot_req_t rq;
    rq.vx = vx; rq.vy = vy; rq.vz = vz;
    rq.ax = ax; rq.ay = ay; rq.az = az;
    rq.ang = ang;
    pending_q.push_back(rq);
  endtask

  initial begin
    logic [31:0] one_q16, half_pi_q16, pi_q16;
    one_q16 = 32'h00010000;
    half_pi_q16 = 32'd102944;
    pi_q16 = 32'd205887;
    // directed: zero axis, unit axes, quarter and half turns, angle edges
    add_req(32'h12345678, 32'h80000000, 32'h7fffffff, 0, 0, 0, 32'h7fffffff);
    add_req(one_q16, 0, 0, 0, 0, one_q16, half_pi_q16);
    add_req(one_q16, 0, 0, 0, 0, one_q16, -half_pi_q16);
    add_req(0, one_q16, 0, one_q16, 0, 0, pi_q16);
    add_req(0, 0, one_q16, 0, one_q16, 0, -pi_q16);
    add_req(one_q16, one_q16, one_q16, one_q16, one_q16, one_q16, 0);
    add_req(one_q16, 2 * one_q16, 3 * one_q16, 1, 0, 0, 32'h80000000);
    add_req(one_q16, 2 * one_q16, 3 * one_q16, 0, 1, 0, 32'h7fffffff);
    // saturation: largest vectors, diagonal axes; then small and zero vectors on one axis
    add_req(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1, 1, 1, half_pi_q16);
    add_req(32'h80000000, 32'h80000000, 32'h80000000, 1, 1, 1, 32'd70000);
    add_req(32'h7fffffff, 32'h80000000, 32'h7fffffff,
            32'h80000000, 32'h80000000, 32'h80000000, 32'd300000);
    add_req(32'h80000000, 32'h7fffffff, 0,
            32'h7fffffff, 32'h7fffffff, 32'h7fffffff, -32'd500000);
    add_req(32'hffffffff, 1, 32'hffffffff, 32'hffffffff, 0, 0, 32'd1);
    add_req(0, 0, 0, 0, 32'h80000000, 0, 32'hffffffff);
    // angle near the fold points
    add_req(one_q16, 0, one_q16, 0, 0, one_q16, half_pi_q16 + 1);
    add_req(one_q16, 0, one_q16, 0, 0, one_q16, pi_q16 + 1);
    add_req(one_q16, 0, one_q16, 0, 0, one_q16, 32'd411775);
    for (int i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(0, 19) == 0)
        add_req(rand_word(), rand_word(), rand_word(), 0, 0, 0, rand_word());
      else
        add_req(rand_word(), rand_word(), rand_word(),
                rand_word(), rand_word(), rand_word(), rand_word());
    end
    stim_done = 1'b1;
  end

  // ---------------------------------------------------------------
  // reset, driver, monitor
  // ---------------------------------------------------------------

  initial begin
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  initial begin
    start = 1'b0;
    in_vec_x = '0; in_vec_y = '0; in_vec_z = '0;
    in_axis_x = '0; in_axis_y = '0; in_axis_z = '0;
    in_turn_angle = '0;
  end

  initial begin
    gap_left = 0;
    n_errors = 0;
    cycle_cnt = 0;
  end

  // driver: new beat at the falling edge, taken at the next rising edge
  always @(negedge clk) begin
    rot_req_t rq;
    rot_res_t rs;
    // the beat presented last cycle was taken at the rising edge just passed
    if (start && !busy_at_edge) begin
      predict_rotation(cur_req, rs);
      expected_q.push_back(rs);
    end
    no_gaps = (pending_q.size() < 200);
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && busy_at_edge) begin
      start <= 1'b1; // hold the beat until taken
    end else if (gap_left > 0) begin
      gap_left--;
      start <= 1'b0;
    end else if (!no_gaps && $urandom_range(0, 7) == 0) begin
      gap_left = $urandom_range(0, 6);
      start <= 1'b0;
    end else if (pending_q.size() > 0) begin
      rq = pending_q.pop_front();
      cur_req = rq;
      in_vec_x <= rq.vx; in_vec_y <= rq.vy; in_vec_z <= rq.vz;
      in_axis_x <= rq.ax; in_axis_y <= rq.ay; in_axis_z <= rq.az;
      in_turn_angle <= rq.ang;
      start <= 1'b1;
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: sample at the rising edge
  always @(posedge clk) begin
    rot_res_t want;
    busy_at_edge <= busy;
    cycle_cnt++;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result beat", 1, 0);
      end else begin
        want = expected_q.pop_front();
        if (out_rot_x !== want.rx) report_mismatch("rot_x", out_rot_x, want.rx);
        if (out_rot_y !== want.ry) report_mismatch("rot_y", out_rot_y, want.ry);
        if (out_rot_z !== want.rz) report_mismatch("rot_z", out_rot_z, want.rz);
        if (out_axis_zero !== want.zero_axis)
          report_mismatch("axis_zero", out_axis_zero, want.zero_axis);
        if (out_saturated !== want.clamped)
          report_mismatch("saturated", out_saturated, want.clamped);
      end
    end
  end

  // end of run: drain, then idle with no beats before the verdict
  initial begin
    int tail;
    wait (stim_done);
    @(posedge clk);
    while (pending_q.size() > 0 || start || expected_q.size() > 0) begin
      @(posedge clk);
      if (cycle_cnt > CYCLE_MAX) begin
        $display("axis_angle_vector_rotation_core: mismatch");
        $finish;
      end
    end
    tail = 0;
    while (tail < 2 * LAT) begin
      @(posedge clk);
      tail++;
    end
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("axis_angle_vector_rotation_core: match");
    end else begin
      $display("axis_angle_vector_rotation_core: mismatch");
    end
    $finish;
  end

endmodule
